### rtl/vag_pkg.sv
// Shared types, constants and coefficient tables of the VAG ADPCM decoder.
package vag_pkg;

    // Width of the stored sample history (signed)
    localparam int HIST_W = 32;
    // Width of a prediction coefficient, in 64ths (signed)
    localparam int COEF_W = 8;
    // Accumulator: two products plus the scaled base term, with headroom
    localparam int ACC_W = HIST_W + COEF_W + 1;

    // Queue between front and back
    localparam int MIDQ_DEPTH = 2;
    localparam int MIDQ_AW    = $clog2(MIDQ_DEPTH);
    localparam int MIDQ_CW    = $clog2(MIDQ_DEPTH + 1);

    // Result queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    // Frame byte positions
    localparam logic [3:0] POS_HEADER = 4'd0;
    localparam logic [3:0] POS_FLAG   = 4'd1;
    localparam logic [3:0] POS_LAST   = 4'd15;

    // Flag value at and above which samples are silenced
    localparam logic [7:0] FLAG_MUTE = 8'h07;

    typedef logic signed [COEF_W-1:0] t_coef;

    // One sample byte, classified and ready for the sample engine
    typedef struct packed {
        logic [7:0] data;
        logic [3:0] shift;
        t_coef      k0;
        t_coef      k1;
        logic       mute;
        logic       last;
    } t_job;

    // One decoded result word
    typedef struct packed {
        logic signed [15:0] sample;
        logic               second;
        logic               eof;
    } t_result;

    // First-tap coefficient; predictors above four fall back to predictor 0
    function automatic t_coef coef_k0(input logic [3:0] pred);
        t_coef k;
        case (pred)
            4'd1:    k = 8'sd60;
            4'd2:    k = 8'sd115;
            4'd3:    k = 8'sd98;
            4'd4:    k = 8'sd122;
            default: k = 8'sd0;
        endcase
        return k;
    endfunction

    // Second-tap coefficient
    function automatic t_coef coef_k1(input logic [3:0] pred);
        t_coef k;
        case (pred)
            4'd2:    k = -8'sd52;
            4'd3:    k = -8'sd55;
            4'd4:    k = -8'sd60;
            default: k = 8'sd0;
        endcase
        return k;
    endfunction

endpackage

### rtl/vag_front.sv
// Front end: frame position tracking, header capture and the job queue.
module vag_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    i_frame_byte,
    output vag_pkg::t_job o_job,
    output logic          o_job_vld,
    input  logic          i_job_pop
);
    import vag_pkg::*;

    logic [3:0]         r_pos;
    logic [3:0]         r_pred;
    logic [3:0]         r_shift;
    logic [7:0]         r_flag;
    t_job               r_q [MIDQ_DEPTH];
    logic [MIDQ_AW-1:0] r_wp;
    logic [MIDQ_AW-1:0] r_rp;
    logic [MIDQ_CW-1:0] r_cnt;

    logic accept;
    logic is_sample;
    logic q_push;
    logic q_pop;
    t_job n_job;

    assign full      = (r_cnt == MIDQ_CW'(MIDQ_DEPTH));
    assign accept    = push && !full;
    assign is_sample = (r_pos != POS_HEADER) && (r_pos != POS_FLAG);
    assign q_push    = accept && is_sample;
    assign q_pop     = i_job_pop && (r_cnt != '0);
    assign o_job_vld = (r_cnt != '0);
    assign o_job     = r_q[r_rp];

    // Classify a sample byte with the header fields in force now
    always_comb begin
        n_job.data  = i_frame_byte;
        n_job.shift = r_shift;
        n_job.k0    = coef_k0(r_pred);
        n_job.k1    = coef_k1(r_pred);
        n_job.mute  = (r_flag >= FLAG_MUTE);
        n_job.last  = (r_pos == POS_LAST);
    end

    // Position and header registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_pred  <= '0;
            r_shift <= '0;
            r_flag  <= '0;
        end else if (accept) begin
            r_pos <= r_pos + 4'd1;
            if (r_pos == POS_HEADER) begin
                r_pred  <= i_frame_byte[7:4];
                r_shift <= i_frame_byte[3:0];
            end else if (r_pos == POS_FLAG) begin
                r_flag <= i_frame_byte;
            end
        end
    end

    // Job queue storage
    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_wp] <= n_job;
        end
    end

    // Job queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (q_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (q_push && !q_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (q_pop && !q_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/vag_back.sv
// Back end: sample engine, one nibble per cycle while the result queue is not full, with the two-sample history.
module vag_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vag_pkg::t_job    i_job,
    input  logic             i_job_vld,
    output logic             o_job_pop,
    input  logic             i_res_full,
    output vag_pkg::t_result o_res,
    output logic             o_res_push
);
    import vag_pkg::*;

    localparam int Q_W = ACC_W - 6;
    localparam int P_W = HIST_W + COEF_W;
    localparam logic signed [Q_W-1:0] HIST_MAX =
        {{(Q_W - HIST_W + 1){1'b0}}, {(HIST_W - 1){1'b1}}};
    localparam logic signed [Q_W-1:0] HIST_MIN =
        {{(Q_W - HIST_W + 1){1'b1}}, {(HIST_W - 1){1'b0}}};
    localparam logic signed [HIST_W-1:0] PCM_MAX = HIST_W'(32767);
    localparam logic signed [HIST_W-1:0] PCM_MIN = HIST_W'(-32768);

    t_job                     r_job;
    logic                     r_vld;
    logic                     r_phase;
    logic signed [HIST_W-1:0] r_hist1;
    logic signed [HIST_W-1:0] r_hist2;

    logic                     step;
    logic                     finish;
    logic [3:0]               nib;
    logic signed [15:0]       scaled;
    logic signed [15:0]       base;
    logic signed [21:0]       base_x64;
    logic signed [P_W-1:0]    prod1;
    logic signed [P_W-1:0]    prod2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  adj;
    logic signed [Q_W-1:0]    quo;
    logic signed [HIST_W-1:0] n_sample;
    logic signed [HIST_W-1:0] pcm;

    // Handshake with the job queue and the result queue
    assign step       = r_vld && !i_res_full;
    assign finish     = step && r_phase;
    assign o_job_pop  = i_job_vld && (!r_vld || finish);
    assign o_res_push = step;

    // Sample arithmetic: base term plus two history taps, truncated toward zero, saturated or muted, then PCM-clamped
    always_comb begin
        nib      = r_phase ? r_job.data[7:4] : r_job.data[3:0];
        scaled   = {nib, 12'b0};
        base     = scaled >>> r_job.shift;
        base_x64 = {base, 6'b0};
        prod1    = r_hist1 * r_job.k0;
        prod2    = r_hist2 * r_job.k1;
        acc      = prod1 + prod2 + base_x64;
        adj      = acc + $signed({{(ACC_W - 6){1'b0}}, {6{acc[ACC_W-1]}}});
        quo      = adj[ACC_W-1:6];
        if (r_job.mute) begin
            n_sample = '0;
        end else if (quo > HIST_MAX) begin
            n_sample = HIST_MAX[HIST_W-1:0];
        end else if (quo < HIST_MIN) begin
            n_sample = HIST_MIN[HIST_W-1:0];
        end else begin
            n_sample = quo[HIST_W-1:0];
        end
        if (n_sample > PCM_MAX) begin
            pcm = PCM_MAX;
        end else if (n_sample < PCM_MIN) begin
            pcm = PCM_MIN;
        end else begin
            pcm = n_sample;
        end
        o_res.sample = pcm[15:0];
        o_res.second = r_phase;
        o_res.eof    = r_phase && r_job.last;
    end

    // Job register and nibble sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (step) begin
                r_phase <= !r_phase;
            end
            if (o_job_pop) begin
                r_vld <= 1'b1;
            end else if (finish) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
    end

    // History: last two unclamped samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist1 <= '0;
            r_hist2 <= '0;
        end else if (step) begin
            r_hist2 <= r_hist1;
            r_hist1 <= n_sample;
        end
    end

endmodule

### rtl/vag_outq.sv
// Result queue between the sample engine and the output port.
module vag_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vag_pkg::t_result i_res,
    input  logic             i_res_push,
    output logic             o_res_full,
    output logic             empty,
    input  logic             pop,
    output vag_pkg::t_result o_head
);
    import vag_pkg::*;

    t_result            r_mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] r_wp;
    logic [OUTQ_AW-1:0] r_rp;
    logic [OUTQ_CW-1:0] r_cnt;

    logic do_pop;

    assign empty      = (r_cnt == '0);
    assign o_res_full = (r_cnt == OUTQ_CW'(OUTQ_DEPTH));
    assign do_pop     = pop && !empty;
    assign o_head     = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_res_push) begin
            r_mem[r_wp] <= i_res;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_res_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_res_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_res_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/vag_adpcm_decoder.sv
// Top level of the VAG ADPCM decoder: front end, sample engine, result queue.
//
// Input channel: a byte word on i_frame_byte is taken when push is high and
// full is low. Bytes form 16-byte frames: header (predictor/shift), flag,
// then 14 sample bytes. Header and flag bytes are taken every cycle while full
// is low and give no result; each sample byte gives two result words, low nibble first.
// Result channel: while empty is low the oldest word is on o_pcm_sample,
// o_second_of_byte and o_end_of_frame; pop with empty low takes it.
// Throughput: the sample engine makes one sample per cycle while the result
// queue has room, so a sample byte gives its two words in turn; the history loop
// (two multiplies, add, saturate) in the engine sets that rate.
// Path: a sample byte passes the job queue, the engine's job register and the
// result queue; its second word follows its first.
// Reset (i_rst_n low at a clock edge) restarts at frame byte 0 with zero
// history and empties both queues.
// When the receiver stalls, the 4-word result queue fills, the engine holds,
// the 2-word job queue fills, and full goes high.
module vag_adpcm_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_frame_byte,
    output logic        empty,
    input  logic        pop,
    output logic signed [15:0] o_pcm_sample,
    output logic        o_second_of_byte,
    output logic        o_end_of_frame
);
    import vag_pkg::*;

    t_job    job;
    logic    job_vld;
    logic    job_pop;
    t_result res;
    logic    res_push;
    logic    res_full;
    t_result head;

    vag_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_frame_byte (i_frame_byte),
        .o_job        (job),
        .o_job_vld    (job_vld),
        .i_job_pop    (job_pop)
    );

    vag_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job),
        .i_job_vld  (job_vld),
        .o_job_pop  (job_pop),
        .i_res_full (res_full),
        .o_res      (res),
        .o_res_push (res_push)
    );

    vag_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (res),
        .i_res_push (res_push),
        .o_res_full (res_full),
        .empty      (empty),
        .pop        (pop),
        .o_head     (head)
    );

    assign o_pcm_sample     = head.sample;
    assign o_second_of_byte = head.second;
    assign o_end_of_frame   = head.eof;

endmodule

### verif/tb_vag_adpcm_decoder.sv
// Self-checking testbench for the VAG ADPCM decoder: directed and random frames against a local decoder.
module tb_vag_adpcm_decoder;
    import vag_pkg::*;

    localparam int N_ITEMS     = 1850;
    localparam int QUIET_ITEMS = 250;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 120;
    localparam int MAX_LINES   = 30;

    // Expected PCM words, computed as frame bytes are accepted
    class pcm_scoreboard;
        logic [3:0] byte_pos;
        logic [3:0] pred;
        logic [3:0] shift;
        logic [7:0] flag;
        longint     hist1;
        longint     hist2;
        t_result    pcm_due[$];
        int         errors;
        // filter taps in 64ths, indexed by predictor
        int         tap0[5] = '{0, 60, 115, 98, 122};
        int         tap1[5] = '{0, 0, -52, -55, -60};

        function new();
            byte_pos = POS_HEADER;
            pred     = '0;
            shift    = '0;
            flag     = '0;
            hist1    = 0;
            hist2    = 0;
            errors   = 0;
        endfunction

        // One unclamped sample, saturated to the history width
        function longint decode_nibble(logic [3:0] nib);
            int     p;
            int     v;
            longint acc;
            longint q;
            longint hmax;
            p = (pred > 4) ? 0 : int'(pred);
            v = $signed(nib);
            v = (v * 4096) >>> shift;
            acc = longint'(v) * 64 + hist1 * tap0[p] + hist2 * tap1[p];
            q = acc / 64;   // truncates toward zero
            hmax = (longint'(1) <<< (HIST_W - 1)) - 1;
            if (q > hmax)
                q = hmax;
            if (q < -hmax - 1)
                q = -hmax - 1;
            return q;
        endfunction

        function void take_byte(logic [7:0] b);
            t_result    r;
            longint     s;
            longint     c;
            logic [3:0] nib;
            case (byte_pos)
                POS_HEADER: begin
                    {pred, shift} = b;
                end
                POS_FLAG: begin
                    flag = b;
                end
                default: begin
                    // low nibble first, then high nibble
                    for (int k = 0; k < 2; k++) begin
                        nib = (k == 1) ? b[7:4] : b[3:0];
                        s = (flag < FLAG_MUTE) ? decode_nibble(nib) : 0;
                        hist2 = hist1;
                        hist1 = s;
                        c = (s > 32767) ? 32767 : ((s < -32768) ? -32768 : s);
                        r.sample = 16'(c);
                        r.second = (k == 1);
                        r.eof    = (k == 1) && (byte_pos == POS_LAST);
                        pcm_due.push_back(r);
                    end
                end
            endcase
            byte_pos = byte_pos + 4'd1;
        endfunction

        task log_mismatch(string msg);
            if (errors < MAX_LINES)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_word(logic signed [15:0] s, logic sec, logic eof);
            t_result e;
            if (pcm_due.size() == 0) begin
                log_mismatch($sformatf("word %0d with nothing pending", s));
            end else begin
                e = pcm_due.pop_front();
                if (s !== e.sample)
                    log_mismatch($sformatf("sample %0d, want %0d", s, e.sample));
                if (sec !== e.second)
                    log_mismatch($sformatf("second_of_byte %b, want %b", sec, e.second));
                if (eof !== e.eof)
                    log_mismatch($sformatf("end_of_frame %b, want %b", eof, e.eof));
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [7:0]         i_frame_byte;
    logic               empty;
    logic               pop;
    logic signed [15:0] o_pcm_sample;
    logic               o_second_of_byte;
    logic               o_end_of_frame;

    pcm_scoreboard sb;
    bit            rst_done = 1'b0;
    bit            quiet    = 1'b0;
    bit            hold_req = 1'b0;
    int            rx_stall = 0;
    int            rx_hold  = 0;
    bit            hold_taken = 1'b0;

    // Extremes: saturating growth, clamp both ways, fallback predictor, max shift, mute
    logic [7:0] directed_bytes [21] = '{
        8'h40, 8'h00, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77,
        8'h88, 8'h88, 8'h88, 8'h88, 8'h0F, 8'hF0, 8'h00, 8'hFF,
        8'hFF, 8'h07, 8'h80, 8'h08, 8'h7F
    };

    vag_adpcm_decoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_frame_byte     (i_frame_byte),
        .empty            (empty),
        .pop              (pop),
        .o_pcm_sample     (o_pcm_sample),
        .o_second_of_byte (o_second_of_byte),
        .o_end_of_frame   (o_end_of_frame)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Random byte for a frame position: mostly valid predictors and live flags
    function automatic logic [7:0] gen_byte(logic [3:0] pos);
        logic [3:0] p;
        logic [7:0] b;
        case (pos)
            POS_HEADER: begin
                p = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 4))
                                               : 4'($urandom_range(5, 15));
                b = {p, 4'($urandom_range(0, 15))};
            end
            POS_FLAG: begin
                b = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 6))
                                               : 8'($urandom_range(7, 255));
            end
            default: begin
                b = 8'($urandom_range(0, 255));
            end
        endcase
        return b;
    endfunction

    // Offer one word, with an optional idle burst in front
    task send_word(input logic [7:0] b, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_frame_byte <= b;
        do @(posedge i_clk); while (full);
        sb.take_byte(b);
    endtask

    // Receiver: check popped words, random stalls, one long hold-off
    initial begin
        while (!rst_done) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (pop && !empty)
                sb.check_word(o_pcm_sample, o_second_of_byte, o_end_of_frame);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                rx_hold    = HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                pop <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                rx_stall = $urandom_range(1, 5) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Reset, directed bytes, random frames, drain
    initial begin
        int n;
        sb = new();
        i_rst_n      <= 1'b0;
        push         <= 1'b0;
        pop          <= 1'b0;
        i_frame_byte <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        for (n = 0; n < $size(directed_bytes); n++)
            send_word(directed_bytes[n], 1'b1);
        for (n = $size(directed_bytes); n < N_ITEMS; n++) begin
            quiet = (n >= N_ITEMS - QUIET_ITEMS);
            if (n == HOLD_AT)
                hold_req = 1'b1;
            send_word(gen_byte(n[3:0]), !quiet);
        end
        push <= 1'b0;

        while (sb.pcm_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial begin
        #(20 * 400000);
        $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
rtl/vag_pkg.sv
rtl/vag_front.sv
rtl/vag_back.sv
rtl/vag_outq.sv
rtl/vag_adpcm_decoder.sv
verif/tb_vag_adpcm_decoder.sv
